>>> design/ppc_pkg.sv
// Package: widths, constants and types for the packet pacing credit clock.
package ppc_pkg;

	localparam int TIME_W  = 64;
	localparam int BYTES_W = 16;
	localparam int RATE_W  = 36;
	localparam int MINW_W  = 16;
	localparam int NUM_W   = 40;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int OUT_W   = 64;
	localparam int IN_W    = 80;

	localparam logic [NUM_W-1:0]  CHARGE_SCALE   = NUM_W'(8 * 1000000);
	localparam logic [MINW_W-1:0] MIN_WAIT_RESET = MINW_W'(500);

	typedef enum logic {
		REG_RATE     = 1'b0,
		REG_MIN_WAIT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctrl_t;

endpackage

>>> design/ppc_div.sv
// Iterative radix-2 restoring divider, one quotient bit per cycle.
module ppc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ppc_pkg::NUM_W-1:0]  num,
	input  logic [ppc_pkg::RATE_W-1:0] den,
	output ppc_pkg::div_ctrl_t         ctrl,
	output logic [ppc_pkg::NUM_W-1:0]  quo
);
	import ppc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [RATE_W:0]   rem_sh;
	logic [RATE_W+1:0] diff;
	logic              fits;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den};
	assign fits   = ~diff[RATE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign ctrl.start = start;
	assign ctrl.done  = done_q;
	assign quo        = quo_q;

endmodule

>>> design/packet_pacing_credit_clock.sv
// Top level: packet pacer on one virtual send time with an iterative charge divider.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tdata: packet_bytes, now_us
//   m_*       out        m_tvalid/m_tready  tdata: wait_us; tuser: hold
//   cfg_*     in         cfg_we             cfg_index, cfg_data
//
// A paced packet passes from acceptance to result through one multiply, one
// compare/subtract, 40 divider steps (one per quotient bit) and one add.
// With pacing off or an empty packet the result is registered at acceptance.
// Reset clears the send time and loads rate 0, minimum wait 500.
// The input is taken only when no packet is in work and the result register is
// free or being drained in the same cycle.
module packet_pacing_credit_clock (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ppc_pkg::IN_W-1:0]     s_tdata,   // packet_bytes[15:0], now_us[79:16]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ppc_pkg::OUT_W-1:0]    m_tdata,   // wait_us[63:0]
	output logic                         m_tuser,   // hold[0]
	input  logic                         cfg_we,
	input  ppc_pkg::cfg_reg_t            cfg_index,
	input  logic [ppc_pkg::RATE_W-1:0]   cfg_data
);
	import ppc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [RATE_W-1:0] rate_q;
	logic [MINW_W-1:0] min_wait_q;
	logic [TIME_W-1:0] next_q;
	logic [TIME_W-1:0] base_q;
	logic [TIME_W-1:0] now_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [NUM_W-1:0]  prod_q;
	logic [TIME_W-1:0] wait_q;
	logic              hold_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;
	logic              m_tuser_q;

	logic [BYTES_W-1:0] in_bytes;
	logic [TIME_W-1:0]  in_now;
	logic               accept;
	logic               bypass;
	logic               out_load;
	logic [TIME_W-1:0]  wait_d;
	logic               div_start;
	div_ctrl_t          div_ctrl;
	logic [NUM_W-1:0]   div_quo;

	assign in_bytes = s_tdata[BYTES_W-1:0];
	assign in_now   = s_tdata[BYTES_W +: TIME_W];
	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign bypass   = (rate_q == '0) || (in_bytes == '0);
	assign out_load = (accept && bypass) || ((state_q == ST_DIV) && div_ctrl.done);
	assign wait_d   = base_q - now_q;
	assign div_start = (state_q == ST_WAIT);

	ppc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (rate_q),
		.ctrl   (div_ctrl),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= '0;
			min_wait_q <= MIN_WAIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RATE:     rate_q     <= cfg_data;
				REG_MIN_WAIT: min_wait_q <= cfg_data[MINW_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			next_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !bypass) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_WAIT;
				ST_WAIT: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_ctrl.done) begin
						next_q  <= base_q + TIME_W'(div_quo);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_q <= in_bytes;
			now_q   <= in_now;
			if (bypass) begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b0;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= NUM_W'(bytes_q) * CHARGE_SCALE;
			base_q <= (next_q < now_q) ? now_q : next_q;
		end
		if (state_q == ST_WAIT) begin
			wait_q <= wait_d;
			hold_q <= (wait_d >= TIME_W'(min_wait_q));
		end
		if ((state_q == ST_DIV) && div_ctrl.done) begin
			m_tdata_q <= hold_q ? OUT_W'(wait_q) : '0;
			m_tuser_q <= hold_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> tb/sv/pacing_checker.sv
// Checker: predicts the pacer's wait/hold result for every accepted packet and compares.
module pacing_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [ppc_pkg::IN_W-1:0]    s_tdata,   // packet_bytes[15:0], now_us[79:16]
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [ppc_pkg::OUT_W-1:0]   m_tdata,   // wait_us[63:0]
	input  logic                        m_tuser,   // hold[0]
	input  logic                        cfg_we,
	input  ppc_pkg::cfg_reg_t           cfg_index,
	input  logic [ppc_pkg::RATE_W-1:0]  cfg_data,
	output int                          errors,
	output int                          pending,
	output int                          results,
	output int                          holds
);
	import ppc_pkg::*;

	typedef struct packed {
		logic              hold;
		logic [OUT_W-1:0]  wait_us;
	} pace_t;

	pace_t              wait_q[$];
	logic [TIME_W-1:0]  send_time_us = '0;
	logic [RATE_W-1:0]  rate_bps = '0;
	logic [MINW_W-1:0]  min_wait_us = MIN_WAIT_RESET;
	int                 err_cnt = 0;
	int                 res_cnt = 0;
	int                 hold_cnt = 0;

	function automatic pace_t pace_packet(input logic [BYTES_W-1:0] nbytes,
			input logic [TIME_W-1:0] now_us);
		pace_t              r;
		logic [TIME_W-1:0]  lag_us;
		logic [TIME_W-1:0]  charge_us;
		r = '0;
		if (rate_bps == '0 || nbytes == '0)
			return r;
		if (send_time_us < now_us)
			send_time_us = now_us;
		lag_us = send_time_us - now_us;
		charge_us = (TIME_W'(nbytes) * TIME_W'(CHARGE_SCALE)) / TIME_W'(rate_bps);
		send_time_us = send_time_us + charge_us;
		if (lag_us >= TIME_W'(min_wait_us)) begin
			r.hold = 1'b1;
			r.wait_us = lag_us;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pace_t exp_r;
		if (!arst_n) begin
			send_time_us = '0;
			rate_bps = '0;
			min_wait_us = MIN_WAIT_RESET;
			wait_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE:     rate_bps = cfg_data;
					REG_MIN_WAIT: min_wait_us = cfg_data[MINW_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				res_cnt++;
				if (m_tuser)
					hold_cnt++;
				if (wait_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, got hold=%0b wait_us=%0d",
						$time, m_tuser, m_tdata);
				end else begin
					exp_r = wait_q.pop_front();
					if (exp_r.hold !== m_tuser || exp_r.wait_us !== m_tdata) begin
						err_cnt++;
						$display("%0t: mismatch, expected hold=%0b wait_us=%0d, got hold=%0b wait_us=%0d",
							$time, exp_r.hold, exp_r.wait_us, m_tuser, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready)
				wait_q.push_back(pace_packet(s_tdata[BYTES_W-1:0],
					s_tdata[BYTES_W +: TIME_W]));
		end
		errors = err_cnt;
		pending = wait_q.size();
		results = res_cnt;
		holds = hold_cnt;
	end

endmodule

>>> tb/sv/tb_packet_pacing_credit_clock.sv
// Testbench top: drives packets and rate settings into the pacer and reports the verdict.
module tb_packet_pacing_credit_clock;
	import ppc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	cfg_reg_t              cfg_index = REG_RATE;
	logic [RATE_W-1:0]     cfg_data = '0;

	int                    errors;
	int                    pending;
	int                    results;
	int                    holds;

	bit                    no_idle = 1'b0;
	int                    rx_hold_off = 0;
	logic [RATE_W-1:0]     rate_now = '0;
	int                    packets_sent = 0;
	int                    settings_used = 0;

	always #10 clk = ~clk;

	packet_pacing_credit_clock dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pacing_checker pace_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.results   (results),
		.holds     (holds)
	);

	task automatic send_packet(input logic [BYTES_W-1:0] nbytes, input logic [TIME_W-1:0] now_us);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {now_us, nbytes};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		packets_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [RATE_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_RATE)
			rate_now = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_pacing(input logic [RATE_W-1:0] rate, input logic [MINW_W-1:0] min_wait);
		wait_idle();
		write_reg(REG_RATE, rate);
		write_reg(REG_MIN_WAIT, {20'($urandom), min_wait});
		settings_used++;
	endtask

	function automatic logic [BYTES_W-1:0] draw_packet_len();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return '0;
		if (sel < 5)
			return BYTES_W'($urandom_range(1, 1500));
		return BYTES_W'($urandom_range(1, 65535));
	endfunction

	// Mostly a clock that advances near the line rate, plus jumps and stale timestamps.
	task automatic run_phase(input int n, input logic [TIME_W-1:0] start_us);
		logic [TIME_W-1:0]   clock_us;
		logic [TIME_W-1:0]   charge_us;
		logic [BYTES_W-1:0]  nbytes;
		int                  pick;
		clock_us = start_us;
		repeat (n) begin
			nbytes = draw_packet_len();
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				send_packet(nbytes, {$urandom, $urandom});
			end else if (pick == 1) begin
				clock_us = {$urandom, $urandom};
				send_packet(nbytes, clock_us);
			end else if (pick == 2) begin
				send_packet(nbytes, clock_us - $urandom_range(0, 5000));
			end else begin
				send_packet(nbytes, clock_us);
				charge_us = (rate_now == '0) ? 64'd100 :
					(TIME_W'(nbytes) * TIME_W'(CHARGE_SCALE)) / TIME_W'(rate_now);
				clock_us = clock_us + charge_us * $urandom_range(0, 200) / 100
					+ $urandom_range(0, 3);
			end
		end
	endtask

	initial begin
		int stall;
		forever begin
			stall = (no_idle ? 0 : $urandom_range(0, 16)) + rx_hold_off;
			rx_hold_off = 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// pacing off after reset
		send_packet(16'd1234, 64'd5);
		send_packet(16'hFFFF, '1);

		set_pacing(36'd8_000_000, 16'd500);
		send_packet(16'd0, 64'd100);
		send_packet(16'd1000, 64'd100);
		send_packet(16'd1000, 64'd200);
		send_packet(16'd100, 64'd1800);
		send_packet(16'hFFFF, 64'd2000);
		send_packet(16'd1, 64'd1_000_000);
		send_packet(16'd1000, 64'hFFFF_FFFF_FFFF_FF00);
		send_packet(16'd1000, 64'hFFFF_FFFF_FFFF_FF80);
		send_packet(16'h8000, 64'd0);

		set_pacing('1, 16'd0);
		send_packet(16'hFFFF, 64'd10_000);
		send_packet(16'hFFFF, 64'd10_000);
		send_packet(16'd1, 64'd10_000);

		set_pacing(36'd1, 16'hFFFF);
		send_packet(16'hFFFF, 64'd20_000);
		send_packet(16'd1, 64'd20_000);
		send_packet(16'hFFFF, '1);

		no_idle = 1'b0;
		set_pacing(36'd8_000_000, 16'd500);
		run_phase(244, {$urandom, $urandom});

		no_idle = 1'b1;
		set_pacing(36'd1_000_000_000, 16'd0);
		rx_hold_off = 400;
		run_phase(244, {$urandom, $urandom});

		no_idle = 1'b0;
		set_pacing('1, 16'd0);
		run_phase(244, {$urandom, $urandom});

		set_pacing(36'd1, 16'hFFFF);
		run_phase(244, 64'hFFFF_FFF0_0000_0000);

		no_idle = 1'b1;
		set_pacing({4'($urandom), 32'($urandom)}, 16'($urandom));
		run_phase(244, {$urandom, $urandom});

		no_idle = 1'b0;
		set_pacing(36'd100_000, 16'($urandom_range(0, 2000)));
		run_phase(244, 64'hFFFF_FFFF_FFF0_0000);

		set_pacing('0, 16'd500);
		run_phase(20, {$urandom, $urandom});

		set_pacing(36'($urandom_range(1, 1 << 20)), 16'($urandom));
		run_phase(244, {$urandom, $urandom});

		no_idle = 1'b1;
		rx_hold_off = 300;
		set_pacing({4'($urandom), 32'($urandom)}, 16'($urandom_range(0, 5000)));
		run_phase(244, {$urandom, $urandom});

		wait_idle();
		$display("Sent %0d packets across %0d rate/threshold settings.",
			packets_sent, settings_used);
		$display("Checked %0d results, %0d of them with hold raised.", results, holds);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
